### hdl/i2c_rts_pkg.sv
package i2c_rts_pkg;

  localparam int TxDepthDefault = 4;

  localparam logic [2:0] ModeLoad    = 3'd0;
  localparam logic [2:0] ModeRead    = 3'd1;
  localparam logic [2:0] ModeWrite   = 3'd2;
  localparam logic [2:0] ModeTxReady = 3'd3;
  localparam logic [2:0] ModeRxByte  = 3'd4;

  localparam logic [2:0] PhaseIdle   = 3'd0;
  localparam logic [2:0] PhaseAddr   = 3'd1;
  localparam logic [2:0] PhaseSwitch = 3'd2;
  localparam logic [2:0] PhaseTx     = 3'd3;
  localparam logic [2:0] PhaseRx     = 3'd4;

  localparam logic [1:0] StartNone = 2'd0;
  localparam logic [1:0] StartTx   = 2'd1;
  localparam logic [1:0] StartRx   = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic [1:0] buffer_slot;
  } req_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [1:0] start_kind;
    logic [6:0] start_address;
    logic       stop_request;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [7:0] read_index;
    logic       transfer_done;
    logic [2:0] phase;
  } rsp_t;

endpackage

### hdl/i2c_register_transaction_sequencer_core.sv
// Register-access sequencer for an I2C master, sitting above a byte-level bus
// controller. Each request is an event (load a write byte, begin a read, begin
// a write, transmitter ready, byte received) and yields exactly one response
// carrying the bus actions to take and the phase afterwards. One request is
// taken every clock cycle while the output is not stalled. The request stage
// reads the transmit buffer memory (TX_DEPTH bytes, one synchronous read
// port); the output stage updates the sequencer registers and fills the
// output register with the response. The buffer address is forwarded from
// the request ahead, so back-to-back requests need no bubble. Buffer entries
// must be loaded before a write sends them.
module i2c_register_transaction_sequencer_core
  import i2c_rts_pkg::*;
#(
  parameter int TX_DEPTH = TxDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int PosW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic [7:0]      store_mem [TX_DEPTH];
  logic [7:0]      rd_data_q;

  logic            b_valid_q;
  req_t            b_req_q;
  logic            out_valid_q;
  rsp_t            out_rsp_q;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      treg_q, treg_d;
  logic [6:0]      tdev_q, tdev_d;
  logic [7:0]      rx_left_q, rx_left_d;
  logic [7:0]      tx_left_q, tx_left_d;
  logic [PosW-1:0] tx_pos_q, tx_pos_d;
  logic [7:0]      rx_pos_q, rx_pos_d;
  logic            armed_q, armed_d;

  logic            b_adv;
  logic            accept;
  rsp_t            rsp;
  logic [8:0]      slot_ext;
  logic            wr_en;
  logic [PosW-1:0] rd_addr;
  logic [7:0]      rx_left_dec;

  assign b_adv      = b_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = b_valid_q && !b_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign slot_ext = 9'(in_req_i.buffer_slot);
  assign wr_en    = accept && (in_req_i.mode == ModeLoad) && (slot_ext < 9'(TX_DEPTH));
  assign rd_addr  = b_adv ? tx_pos_d : tx_pos_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[slot_ext[PosW-1:0]] <= in_req_i.data_byte;
    end
    if (accept) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign rx_left_dec = rx_left_q - 8'd1;

  always_comb begin
    rsp       = '0;
    phase_d   = phase_q;
    treg_d    = treg_q;
    tdev_d    = tdev_q;
    rx_left_d = rx_left_q;
    tx_left_d = tx_left_q;
    tx_pos_d  = tx_pos_q;
    rx_pos_d  = rx_pos_q;
    armed_d   = armed_q;
    unique case (b_req_q.mode)
      ModeRead, ModeWrite: begin
        phase_d  = PhaseAddr;
        treg_d   = b_req_q.register_address;
        tdev_d   = b_req_q.device_address;
        tx_pos_d = '0;
        rx_pos_d = '0;
        armed_d  = 1'b0;
        if (b_req_q.mode == ModeRead) begin
          rx_left_d = b_req_q.byte_count;
          tx_left_d = '0;
        end else begin
          rx_left_d = '0;
          tx_left_d = (9'(b_req_q.byte_count) > 9'(TX_DEPTH)) ? 8'(TX_DEPTH)
                                                                 : b_req_q.byte_count;
        end
        rsp.start_kind    = StartTx;
        rsp.start_address = b_req_q.device_address;
      end
      ModeTxReady: begin
        priority if (phase_q == PhaseAddr) begin
          rsp.send_valid = 1'b1;
          rsp.send_byte  = treg_q;
          phase_d        = (rx_left_q != '0) ? PhaseSwitch : PhaseTx;
        end else if (phase_q == PhaseSwitch) begin
          armed_d           = 1'b1;
          phase_d           = PhaseRx;
          rsp.start_kind    = StartRx;
          rsp.start_address = tdev_q;
          rsp.stop_request  = (rx_left_q == 8'd1);
        end else if (phase_q == PhaseTx) begin
          if (tx_left_q != '0) begin
            rsp.send_valid = 1'b1;
            rsp.send_byte  = rd_data_q;
            tx_pos_d       = tx_pos_q + PosW'(1);
            tx_left_d      = tx_left_q - 8'd1;
          end else begin
            rsp.stop_request  = 1'b1;
            rsp.transfer_done = 1'b1;
            phase_d           = PhaseIdle;
          end
        end else begin
        end
      end
      ModeRxByte: begin
        if (armed_q) begin
          if (rx_left_q != '0) begin
            rsp.read_valid = 1'b1;
            rsp.read_byte  = b_req_q.data_byte;
            rsp.read_index = rx_pos_q;
            rx_pos_d       = rx_pos_q + 8'd1;
            rx_left_d      = rx_left_dec;
          end
          if (rx_left_d == 8'd1) begin
            rsp.stop_request = 1'b1;
          end else if (rx_left_d == '0) begin
            armed_d           = 1'b0;
            phase_d           = PhaseIdle;
            rsp.transfer_done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhaseIdle;
      treg_q      <= '0;
      tdev_q      <= '0;
      rx_left_q   <= '0;
      tx_left_q   <= '0;
      tx_pos_q    <= '0;
      rx_pos_q    <= '0;
      armed_q     <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        treg_q      <= treg_d;
        tdev_q      <= tdev_d;
        rx_left_q   <= rx_left_d;
        tx_left_q   <= tx_left_d;
        tx_pos_q    <= tx_pos_d;
        rx_pos_q    <= rx_pos_d;
        armed_q     <= armed_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_req_q <= in_req_i;
    end
    if (b_adv) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
